### src/linear_probe_hash_table_unit_assert.svh
// assertion macros for the linear probing hash table unit
// used by the port checker; no other dependencies
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// next-cycle implication
`define LPHT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`endif

### src/lpht_pkg.sv
// types, codes and constants of the linear probing hash table unit
// used by the top level and its port checker
package lpht_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_BYTES_DEF   = 8;
   localparam int KEY_MAX_W       = 64;
   localparam int HASH_W          = 32;
   localparam int MOD_BITS        = 4;
   localparam int BYTE_SUM_W      = 11;
   localparam int CSR_W           = 7;
   localparam int STATUS_W        = 3;
   localparam int SLOT_W          = 6;
   localparam int COUNT_W         = 16;
   localparam int MODE_W          = 2;

   localparam logic [CSR_W-1:0]  SIZE_RESET  = 7'd50;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_CLEARED = 3'd0,
      ST_PLACED  = 3'd1,
      ST_FULL    = 3'd2,
      ST_FOUND   = 3'd3,
      ST_MISSING = 3'd4,
      ST_EMPTY   = 3'd5
   } lpht_status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_CLEAR,
      S_REPLY
   } lpht_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [KEY_MAX_W-1:0] key;
   } lpht_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   position;
      logic [SLOT_W-1:0]   home_slot;
      logic [COUNT_W-1:0]  collision_count;
   } lpht_rsp_type;

endpackage

### src/linear_probe_hash_table_unit.sv
// linear probing hash table unit: open-addressing key table in one synchronous memory
// depends on lpht_pkg
//
// items arrive on req_valid/req_ready with a mode and an 8-byte key; one result item per
// request leaves on rsp_valid/rsp_ready. csr_wr_en/csr_wr_data set the ring size at once.
// insert and lookup: the item is accepted while idle, then hashed (4 remainder bits per
// cycle), then one memory read per probed slot, pipelined so a probe issues every cycle,
// then the result is loaded into the output register once it is free. an empty key goes
// straight to the reply, skipping hashing and probing; clear sweeps every entry.
// one item is in work at a time; req_ready is high only while idle, and a new item is
// taken while the previous result still waits in the output register.
// a stalled receiver holds the result; the unit finishes its next item and then waits.
// after reset a clearing pass over every entry runs with req_ready low; the ring
// size returns to 50 and the collision count to zero.
module linear_probe_hash_table_unit #(
   parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [lpht_pkg::CSR_W-1:0] csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lpht_pkg::lpht_req_type   req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lpht_pkg::lpht_rsp_type   rsp_item
);
   import lpht_pkg::*;

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int REM_W     = IDX_W + 1;
   localparam int KEY_W     = 8 * KEY_BYTES;
   localparam int WORD_W    = KEY_W + 1;
   localparam int SIZE_W    = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int MOD_STEPS = HASH_W / MOD_BITS;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   lpht_state_type          state_ff, state_in;
   logic [CSR_W-1:0]        table_size_ff, table_size_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic                    insert_ff, insert_in;
   logic [CNT_W-1:0]        ring_ff, ring_in;
   logic [HASH_W-1:0]       dividend_ff, dividend_in;
   logic [IDX_W-1:0]        rem_ff, rem_in;
   logic [STEP_W-1:0]       mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]        home_ff, home_in;
   logic [IDX_W-1:0]        iss_addr_ff, iss_addr_in;
   logic [CNT_W-1:0]        iss_cnt_ff, iss_cnt_in;
   logic                    chk_valid_ff, chk_valid_in;
   logic                    chk_first_ff, chk_first_in;
   logic                    chk_last_ff, chk_last_in;
   logic [IDX_W-1:0]        chk_addr_ff, chk_addr_in;
   logic [IDX_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]      coll_ff, coll_in;
   lpht_status_type         status_ff, status_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lpht_rsp_type            rsp_ff, rsp_in;
   logic [WORD_W-1:0]       mem_rd_data_ff;

   logic [WORD_W-1:0]       table_mem [TABLE_DEPTH];
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic [WORD_W-1:0]       mem_wr_data;

   logic [SIZE_W-1:0]       size_ext;
   logic [CNT_W-1:0]        ring_size;
   logic [KEY_W-1:0]        key_norm;
   logic [BYTE_SUM_W-1:0]   byte_sum;
   logic                    alive;
   logic [REM_W-1:0]        rem_step;
   logic [IDX_W-1:0]        rem_next;
   logic                    req_accept;
   logic                    rsp_free;
   logic                    slot_used;
   logic                    key_match;
   logic                    hit;
   logic                    probe_done;
   logic                    mod_last;
   logic                    clr_last;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   assign slot_used  = mem_rd_data_ff[KEY_W];
   assign key_match  = slot_used && (mem_rd_data_ff[KEY_W-1:0] == key_ff);
   assign hit        = insert_ff ? !slot_used : key_match;
   assign probe_done = chk_valid_ff && (hit || chk_last_ff);
   assign mod_last   = (mod_cnt_ff == STEP_W'(MOD_STEPS - 1));
   assign clr_last   = (clr_addr_ff == IDX_W'(TABLE_DEPTH - 1));

   // effective ring size
   always_comb begin
      size_ext = SIZE_W'(table_size_ff);
      priority if (size_ext == '0) begin
         ring_size = CNT_W'(1);
      end else if (size_ext > SIZE_W'(TABLE_DEPTH)) begin
         ring_size = CNT_W'(TABLE_DEPTH);
      end else begin
         ring_size = CNT_W'(size_ext);
      end
   end

   // key normalisation and signed byte sum
   always_comb begin
      key_norm = '0;
      byte_sum = '0;
      alive    = 1'b1;
      for (int b = 0; b < KEY_BYTES; b++) begin
         alive = alive && (req_item.key[8*b +: 8] != 8'd0);
         if (alive) begin
            key_norm[8*b +: 8] = req_item.key[8*b +: 8];
            byte_sum = byte_sum
                     + {{(BYTE_SUM_W-8){req_item.key[8*b+7]}}, req_item.key[8*b +: 8]};
         end
      end
   end

   // restoring remainder, several bits a cycle
   always_comb begin
      rem_step = REM_W'(rem_ff);
      for (int s = 0; s < MOD_BITS; s++) begin
         rem_step = {rem_step[REM_W-2:0], dividend_ff[HASH_W-1-s]};
         if (rem_step >= REM_W'(ring_ff)) begin
            rem_step = rem_step - REM_W'(ring_ff);
         end
      end
      rem_next = IDX_W'(rem_step);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               priority if (req_item.mode == MODE_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (key_norm == '0) begin
                  state_in = S_REPLY;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (mod_last) state_in = S_PROBE;
         end
         S_PROBE: begin
            if (probe_done) state_in = S_REPLY;
         end
         S_CLEAR: begin
            if (clr_last) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // datapath and outputs
   always_comb begin
      table_size_in = csr_wr_en ? csr_wr_data : table_size_ff;
      key_in        = key_ff;
      insert_in     = insert_ff;
      ring_in       = ring_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      home_in       = home_ff;
      iss_addr_in   = iss_addr_ff;
      iss_cnt_in    = iss_cnt_ff;
      chk_valid_in  = 1'b0;
      chk_first_in  = chk_first_ff;
      chk_last_in   = chk_last_ff;
      chk_addr_in   = chk_addr_ff;
      clr_addr_in   = clr_addr_ff;
      coll_in       = coll_ff;
      status_in     = status_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = clr_addr_ff;
      mem_wr_data   = '0;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               key_in      = key_norm;
               insert_in   = (req_item.mode == MODE_INSERT);
               ring_in     = ring_size;
               dividend_in = {{(HASH_W-BYTE_SUM_W){byte_sum[BYTE_SUM_W-1]}}, byte_sum};
               rem_in      = '0;
               mod_cnt_in  = '0;
               clr_addr_in = '0;
               pos_in      = '0;
               home_in     = '0;
               if (req_item.mode == MODE_CLEAR) begin
                  coll_in   = '0;
                  status_in = ST_CLEARED;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
         end
         S_HASH: begin
            dividend_in = dividend_ff << MOD_BITS;
            rem_in      = rem_next;
            mod_cnt_in  = mod_cnt_ff + STEP_W'(1);
            if (mod_last) begin
               home_in     = rem_next;
               iss_addr_in = rem_next;
               iss_cnt_in  = '0;
            end
         end
         S_PROBE: begin
            // issue one read a cycle, check the one issued last cycle
            if (iss_cnt_ff != ring_ff && !probe_done) begin
               chk_valid_in = 1'b1;
               chk_addr_in  = iss_addr_ff;
               chk_first_in = (iss_cnt_ff == '0);
               chk_last_in  = (iss_cnt_ff == ring_ff - CNT_W'(1));
               iss_cnt_in   = iss_cnt_ff + CNT_W'(1);
               iss_addr_in  = (CNT_W'(iss_addr_ff) == ring_ff - CNT_W'(1)) ? '0
                            : iss_addr_ff + IDX_W'(1);
            end
            if (chk_valid_ff) begin
               if (insert_ff && chk_first_ff && slot_used && (coll_ff != '1)) begin
                  coll_in = coll_ff + COUNT_W'(1);
               end
               if (hit) begin
                  pos_in = chk_addr_ff;
                  if (insert_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = chk_addr_ff;
                     mem_wr_data = {1'b1, key_ff};
                     status_in   = ST_PLACED;
                  end else begin
                     status_in   = ST_FOUND;
                  end
               end else if (chk_last_ff) begin
                  pos_in    = '0;
                  status_in = insert_ff ? ST_FULL : ST_MISSING;
               end
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.position        = SLOT_W'(pos_ff);
               rsp_in.home_slot       = SLOT_W'(home_ff);
               rsp_in.collision_count = coll_ff;
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // slot memory: {used, key}
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         table_mem[mem_wr_addr] <= mem_wr_data;
      end
      mem_rd_data_ff <= table_mem[iss_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         table_size_ff <= SIZE_RESET;
         clr_addr_ff   <= '0;
         coll_ff       <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         clr_addr_ff   <= clr_addr_in;
         coll_ff       <= coll_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      insert_ff    <= insert_in;
      ring_ff      <= ring_in;
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      home_ff      <= home_in;
      iss_addr_ff  <= iss_addr_in;
      iss_cnt_ff   <= iss_cnt_in;
      chk_first_ff <= chk_first_in;
      chk_last_ff  <= chk_last_in;
      chk_addr_ff  <= chk_addr_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      rsp_ff       <= rsp_in;
   end

endmodule

### src/lpht_checker.sv
// port checker for the linear probing hash table unit, bound to the top level
// depends on lpht_pkg and linear_probe_hash_table_unit_assert.svh
`include "linear_probe_hash_table_unit_assert.svh"

module lpht_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lpht_pkg::lpht_rsp_type rsp_item
);
   import lpht_pkg::*;

   `LPHT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))
   `LPHT_ASSERT_NXT(a_one_item_in_work, clock, reset, req_valid && req_ready, !req_ready)
   `LPHT_ASSERT_IMP(a_cleared_zero, clock, reset, rsp_valid && (rsp_item.status == ST_CLEARED), (rsp_item.collision_count == '0) && (rsp_item.position == '0))
   `LPHT_ASSERT_IMP(a_no_home, clock, reset, rsp_valid && ((rsp_item.status == ST_CLEARED) || (rsp_item.status == ST_EMPTY)), rsp_item.home_slot == '0)
   `LPHT_ASSERT_IMP(a_miss_pos, clock, reset, rsp_valid && ((rsp_item.status == ST_FULL) || (rsp_item.status == ST_MISSING)), rsp_item.position == '0)

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

### tb/tb_linear_probe_hash_table_unit.sv
// testbench for linear_probe_hash_table_unit: a directed table, then random bursts over
// several ring sizes, each result checked against a typed row or the in-line predictor
// depends on lpht_pkg and the unit's rtl
module tb_linear_probe_hash_table_unit;
   import lpht_pkg::*;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
   localparam int RING_MAX = 64;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_type;

   typedef struct {
      bit                resize;
      logic [CSR_W-1:0]  new_size;
      lpht_req_type      req;
      bit                typed;
      lpht_rsp_type      want;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [CSR_W-1:0]   csr_wr_data;
   logic               req_valid;
   logic               req_ready;
   lpht_req_type       req_item;
   logic               rsp_valid;
   logic               rsp_ready;
   lpht_rsp_type       rsp_item;

   // predictor state
   bit                 slot_taken [RING_MAX];
   logic [63:0]        stored_key [RING_MAX];
   logic [COUNT_W-1:0] collision_tally;
   logic [CSR_W-1:0]   ring_setting;

   lpht_rsp_type       pending_results [$];
   table_row_type      directed_rows [$];
   int                 items_accepted;
   int                 burst_left;
   int                 mismatches;

   linear_probe_hash_table_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic lpht_rsp_type predict_table_op(input lpht_req_type r);
      lpht_rsp_type res;
      logic [63:0]  norm;
      logic [31:0]  sum;
      logic [7:0]   kb;
      int           ring, home, j, i, b;
      bit           ended, hit;
      res = '0;
      ring = (ring_setting == 0) ? 1 : (ring_setting > RING_MAX) ? RING_MAX : int'(ring_setting);
      if (r.mode == MODE_CLEAR) begin
         foreach (slot_taken[s]) begin
            slot_taken[s] = 1'b0;
            stored_key[s] = '0;
         end
         collision_tally = '0;
         res.status = ST_CLEARED;
      end else begin
         norm = '0;
         sum = '0;
         ended = 1'b0;
         for (b = 0; b < 8; b++) begin
            kb = r.key[8*b +: 8];
            if (kb == 8'h00) ended = 1'b1;
            if (!ended) begin
               norm[8*b +: 8] = kb;
               sum = sum + {{24{kb[7]}}, kb};
            end
         end
         if (norm == '0) begin
            res.status = ST_EMPTY;
         end else begin
            home = int'(sum % 32'(ring));
            res.home_slot = 6'(home);
            hit = 1'b0;
            j = home;
            if (r.mode == MODE_INSERT) begin
               res.status = ST_FULL;
               if (slot_taken[home] && collision_tally != 16'hFFFF)
                  collision_tally = collision_tally + 1'b1;
               for (i = 0; i < ring && !hit; i++) begin
                  if (!slot_taken[j]) begin
                     slot_taken[j] = 1'b1;
                     stored_key[j] = norm;
                     res.status = ST_PLACED;
                     res.position = 6'(j);
                     hit = 1'b1;
                  end
                  j = (j + 1 == ring) ? 0 : j + 1;
               end
            end else begin
               res.status = ST_MISSING;
               for (i = 0; i < ring && !hit; i++) begin
                  if (slot_taken[j] && stored_key[j] == norm) begin
                     res.status = ST_FOUND;
                     res.position = 6'(j);
                     hit = 1'b1;
                  end
                  j = (j + 1 == ring) ? 0 : j + 1;
               end
            end
         end
      end
      res.collision_count = collision_tally;
      return res;
   endfunction

   function automatic logic [63:0] random_key();
      logic [63:0] k;
      int          len, b;
      k = '0;
      len = $urandom_range(1, 8);
      for (b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
      return k;
   endfunction

   // fill the bytes after the terminating zero byte with noise
   function automatic logic [63:0] with_trailing_junk(input logic [63:0] k);
      int z, b;
      z = 8;
      for (b = 7; b >= 0; b--) if (k[8*b +: 8] == 8'h00) z = b;
      for (b = z + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom);
      return k;
   endfunction

   task automatic add_row(input logic [MODE_W-1:0] m, input logic [63:0] k);
      table_row_type row;
      row = '{default: '0};
      row.req.mode = m;
      row.req.key = k;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [MODE_W-1:0] m, input logic [63:0] k,
                            input lpht_status_type st, input int pos, input int home,
                            input int cnt);
      table_row_type row;
      row = '{default: '0};
      row.req.mode = m;
      row.req.key = k;
      row.typed = 1'b1;
      row.want.status = st;
      row.want.position = 6'(pos);
      row.want.home_slot = 6'(home);
      row.want.collision_count = 16'(cnt);
      directed_rows.push_back(row);
   endtask

   task automatic add_resize(input logic [CSR_W-1:0] sz);
      table_row_type row;
      row = '{default: '0};
      row.resize = 1'b1;
      row.new_size = sz;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input lpht_req_type r, input bit typed, input lpht_rsp_type want);
      int           gap;
      lpht_rsp_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = predict_table_op(r);
      pending_results.push_back(typed ? want : predicted);
      items_accepted++;
   endtask

   task automatic program_size(input logic [CSR_W-1:0] sz);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= sz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ring_setting = sz;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      lpht_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: %h", rsp_item);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 16'(want.status), 16'(rsp_item.status));
            compare_field("position", 16'(want.position), 16'(rsp_item.position));
            compare_field("home_slot", 16'(want.home_slot), 16'(rsp_item.home_slot));
            compare_field("collision_count", want.collision_count, rsp_item.collision_count);
         end
      end
   end

   // receiver: stall patterns in random stretches, plus two long hold-offs
   initial begin
      int           stretch, hold, holds_done, ticks;
      rx_style_type style;
      rsp_ready = 1'b0;
      stretch = 0;
      hold = 0;
      holds_done = 0;
      ticks = 0;
      style = RX_OPEN;
      forever begin
         @(posedge clock);
         ticks++;
         if (hold == 0 && holds_done < 2 &&
             items_accepted >= ((holds_done == 0) ? 300 : 1100)) begin
            hold = 500;
            holds_done++;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(20, 300);
               style = rx_style_type'($urandom_range(0, 3));
            end
            stretch--;
            case (style)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= 1'(ticks >> 2);
            endcase
         end
      end
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [CSR_W-1:0] phase_size [8];
      logic [63:0]      key_pool [16];
      logic [63:0]      k;
      lpht_req_type     r;
      int               p, n, i, pool_n, pick;
      phase_size = '{7'd50, 7'd1, 7'd64, 7'd3, 7'd127, 7'd0, 7'd2, 7'd64};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_item = '0;
      clock = 1'b0;
      items_accepted = 0;
      burst_left = 0;
      mismatches = 0;
      ring_setting = SIZE_RESET;
      r = '0;
      void'(predict_table_op(r));

      // hashing, normalisation, empty keys and spare mode at the reset size
      add_typed(MODE_LOOKUP, 64'h41, ST_MISSING, 0, 15, 0);
      add_typed(MODE_INSERT, 64'h41, ST_PLACED, 15, 15, 0);
      add_typed(MODE_INSERT, 64'h41, ST_PLACED, 16, 15, 1);
      add_typed(MODE_LOOKUP, 64'hFFFF_FFFF_FF00_0041, ST_FOUND, 15, 15, 1);
      add_typed(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FF00, ST_EMPTY, 0, 0, 1);
      add_typed(MODE_LOOKUP, 64'h0, ST_EMPTY, 0, 0, 1);
      add_row(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
      add_row(MODE_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
      add_row(MODE_INSERT, 64'h8080_8080_8080_8080);
      add_row(MODE_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7F);
      add_row(MODE_INSERT, 64'h0102_0304_0506_0708);
      add_typed(MODE_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, ST_CLEARED, 0, 0, 0);
      // single slot ring, full ring drop, zero size acting as one
      add_resize(7'd1);
      add_typed(MODE_INSERT, 64'h41, ST_PLACED, 0, 0, 0);
      add_typed(MODE_INSERT, 64'h42, ST_FULL, 0, 0, 1);
      add_typed(MODE_LOOKUP, 64'h42, ST_MISSING, 0, 0, 1);
      add_resize(7'd0);
      add_typed(MODE_LOOKUP, 64'h41, ST_FOUND, 0, 0, 1);
      add_typed(MODE_INSERT, 64'h43, ST_FULL, 0, 0, 2);
      // oversize setting, wrap at the ring end, shrink while filled
      add_resize(7'd127);
      add_typed(MODE_INSERT, 64'h41, ST_PLACED, 1, 1, 2);
      add_typed(MODE_INSERT, 64'h3F, ST_PLACED, 63, 63, 2);
      add_row(MODE_INSERT, 64'h3F);
      add_resize(7'd64);
      add_typed(MODE_LOOKUP, 64'h3F, ST_FOUND, 63, 63, 3);
      add_resize(7'd2);
      add_typed(MODE_LOOKUP, 64'h3F, ST_MISSING, 0, 1, 3);
      add_typed(MODE_LOOKUP, 64'h41, ST_FOUND, 1, 1, 3);
      add_row(MODE_INSERT, 64'hFF);
      add_typed(MODE_CLEAR, 64'h0, ST_CLEARED, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[d]) begin
         if (directed_rows[d].resize)
            program_size(directed_rows[d].new_size);
         else
            send_request(directed_rows[d].req, directed_rows[d].typed, directed_rows[d].want);
      end

      for (p = 0; p < 10; p++) begin
         program_size((p < 8) ? phase_size[p] : 7'($urandom_range(0, 127)));
         pool_n = $urandom_range(4, 16);
         for (i = 0; i < pool_n; i++) key_pool[i] = random_key();
         for (n = 0; n < 150; n++) begin
            pick = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 2) == 0) k = with_trailing_junk(k);
            if (pick == 0) begin
               r.mode = MODE_CLEAR;
               k = {$urandom, $urandom};
            end else if (pick < 44) begin
               r.mode = MODE_INSERT;
            end else if (pick < 80) begin
               r.mode = MODE_LOOKUP;
            end else if (pick < 86) begin
               r.mode = MODE_INSERT;
               k = with_trailing_junk(random_key());
            end else if (pick < 91) begin
               r.mode = MODE_LOOKUP;
               k = with_trailing_junk(random_key());
            end else if (pick < 96) begin
               r.mode = MODE_SPARE;
            end else begin
               r.mode = ($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_LOOKUP;
               k = with_trailing_junk(64'h0);
            end
            r.key = k;
            send_request(r, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
